FILE: rtl/tssr_pkg.sv
// Package for the triangle scanline span rasterizer.
// Holds operation and fill phase codes, the configuration reset value
// and the divider status struct. No dependencies.
package tssr_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TOP    = 2'd1;
  localparam logic [1:0] PH_BOTTOM = 2'd2;

  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] CFG_WIDTH_RESET = 13'd640;

  typedef struct packed {
    logic busy;
    logic done;
  } tssr_div_stat_t;

endpackage

FILE: rtl/tssr_divider.sv
// Shared restoring divider, one quotient bit per cycle, truncates toward zero.
// Signed numerator, positive unsigned divisor. Uses tssr_pkg.
module tssr_divider #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic        [DEN_W-1:0]  den_i,
  output tssr_pkg::tssr_div_stat_t stat_o,
  output logic signed [NUM_W-1:0]  quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             neg_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [NUM_W-1:0] mag;

  assign mag   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      den_q <= den_i;
      rem_q <= '0;
      acc_q <= mag;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      acc_q <= {acc_q[NUM_W-2:0], fits};
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quo_o       = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

FILE: rtl/triangle_scanline_span_rasterizer_top.sv
// Top level of the triangle scanline span rasterizer.
// Sequencer, edge registers and span datapath; uses tssr_pkg and tssr_divider.
//
// Usage:
//   s_axis carries one word per item. tuser is the operation: load (0) takes
//   three vertices and a label from tdata; step (1) asks for the next span.
//   m_axis returns one span word per step while a triangle is active; tlast
//   marks the final span and tuser flags an empty span.
//   cfg_we_i/cfg_wdata_i write the image width; the user must do so only
//   while the block is idle, which the block itself does not enforce.
// Sequencing:
//   A step is accepted in ST_IDLE, then ST_SPAN loads the span register.
//   A load of a zero-height triangle returns to idle after setup. Any other
//   load then finds the split column (skipped for a flat bottom) and each of
//   the two inverse slopes, each either directly or by one division in the
//   shared divider. The step that crosses the middle row adds the two slope
//   stages again. tready stays low while the sequencer is busy.
// Reset: no triangle is active, width reads 640, steps give nothing.
// Stall: a span waits in the output register; a new item is accepted only
//   when that register is empty or being taken in the same cycle.
module triangle_scanline_span_rasterizer_top #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned LABEL_BITS = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tssr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // x_a, y_a, x_b, y_b, x_c, y_c, triangle_index, zero fill
  input  logic [((6*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // operation
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // span_row, span_start, span_end, span_label, zero fill
  output logic [((3*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // span_empty
  output logic                       m_axis_tuser_o,
  // last_span
  output logic                       m_axis_tlast_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned POS_W = C + F + 3;
  localparam int unsigned QI_W  = POS_W - F;
  localparam int unsigned NUM_W = 2*C + F + 1;
  localparam int unsigned OUT_W = ((3*C+LABEL_BITS+7)/8)*8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETUP = 4'd1;
  localparam logic [3:0] ST_MID   = 4'd2;
  localparam logic [3:0] ST_MID_W = 4'd3;
  localparam logic [3:0] ST_E0    = 4'd4;
  localparam logic [3:0] ST_E0_W  = 4'd5;
  localparam logic [3:0] ST_E1    = 4'd6;
  localparam logic [3:0] ST_E1_W  = 4'd7;
  localparam logic [3:0] ST_SPAN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [tssr_pkg::CFG_W-1:0] width_q;
  logic [C-1:0] sx_q [3];
  logic [C-1:0] sy_q [3];
  logic [LABEL_BITS-1:0] label_q;
  logic signed [POS_W-1:0] split_q;
  logic signed [POS_W-1:0] pos_q [2];
  logic signed [POS_W-1:0] step_q [2];
  logic vert_q [2];
  logic [C-1:0] row_q;
  logic [1:0] phase_q;
  logic bottom_q;

  logic out_valid_q, out_empty_q, out_last_q;
  logic [C-1:0] out_row_q, out_start_q, out_end_q;
  logic [LABEL_BITS-1:0] out_label_q;

  logic in_acc;
  logic [2*C-1:0] key [3];
  logic [2*C-1:0] srt [3];
  logic [2*C-1:0] tmp;

  logic div_start;
  logic signed [NUM_W-1:0] div_num;
  logic [C-1:0] div_den;
  tssr_pkg::tssr_div_stat_t div_stat;
  logic signed [NUM_W-1:0] div_quo;
  logic signed [POS_W-1:0] quo;

  logic signed [POS_W-1:0] xq0, xq1, xq2, f0, num0, num1;
  logic signed [2*C:0] prod;
  logic [C-1:0] den_e;

  logic signed [POS_W-1:0] lo, hi, lo_c, hi_c, lim, one_m1;
  logic signed [QI_W-1:0] s_i, e_i;
  logic [31:0] wext;
  logic [C-1:0] lim_col;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);

  // sort by row, then column
  always_comb begin
    tmp    = '0;
    key[0] = {s_axis_tdata_i[2*C-1:C],   s_axis_tdata_i[C-1:0]};
    key[1] = {s_axis_tdata_i[4*C-1:3*C], s_axis_tdata_i[3*C-1:2*C]};
    key[2] = {s_axis_tdata_i[6*C-1:5*C], s_axis_tdata_i[5*C-1:4*C]};
    srt[0] = key[0];
    srt[1] = key[1];
    srt[2] = key[2];
    if (srt[0] > srt[1]) begin
      tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
    end
    if (srt[1] > srt[2]) begin
      tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp;
    end
    if (srt[0] > srt[1]) begin
      tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
    end
  end

  assign xq0 = $signed({3'b000, sx_q[0], {F{1'b0}}});
  assign xq1 = $signed({3'b000, sx_q[1], {F{1'b0}}});
  assign xq2 = $signed({3'b000, sx_q[2], {F{1'b0}}});
  assign f0  = (sy_q[0] == sy_q[1]) ? xq0 : xq1;
  assign num0 = bottom_q ? (xq1 - xq0) : (xq2 - f0);
  assign num1 = bottom_q ? (split_q - xq0) : (xq2 - split_q);
  assign den_e = bottom_q ? (sy_q[1] - sy_q[0]) : (sy_q[2] - sy_q[1]);
  assign prod = $signed({1'b0, sy_q[1] - sy_q[0]}) *
                $signed({1'b0, sx_q[2]} - {1'b0, sx_q[0]});
  assign quo = div_quo[POS_W-1:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(num0);
    div_den   = den_e;
    case (state_q)
      ST_MID: begin
        div_start = (sy_q[0] != sy_q[1]);
        div_num   = $signed({prod, {F{1'b0}}});
        div_den   = sy_q[2] - sy_q[0];
      end
      ST_E0: begin
        div_start = (num0 != '0);
        div_num   = NUM_W'(num0);
      end
      ST_E1: begin
        div_start = (num1 != '0);
        div_num   = NUM_W'(num1);
      end
      default: ;
    endcase
  end

  tssr_divider #(
    .NUM_W(NUM_W),
    .DEN_W(C)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // span datapath
  always_comb begin
    wext = 32'(width_q);
    if (wext == 32'd0) begin
      lim_col = '0;
    end else if (wext > (32'd1 << C)) begin
      lim_col = {C{1'b1}};
    end else begin
      lim_col = C'(wext - 32'd1);
    end
    lim    = $signed({3'b000, lim_col, {F{1'b0}}});
    one_m1 = $signed({{(POS_W-F){1'b0}}, {F{1'b1}}});
    lo     = (pos_q[0] < pos_q[1]) ? pos_q[0] : pos_q[1];
    hi     = (pos_q[0] < pos_q[1]) ? pos_q[1] : pos_q[0];
    lo_c   = (lo < 0) ? '0 : lo;
    hi_c   = (hi > lim) ? lim : hi;
    s_i    = QI_W'(lo_c >>> F);
    e_i    = QI_W'((hi_c + ((hi_c < 0) ? one_m1 : '0)) >>> F);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == tssr_pkg::OP_LOAD) begin
            state_d = ST_SETUP;
          end else if (phase_q != tssr_pkg::PH_IDLE) begin
            state_d = ST_SPAN;
          end
        end
      end
      ST_SETUP: begin
        if (sy_q[0] == sy_q[2]) begin
          state_d = ST_IDLE;
        end else if (sy_q[1] == sy_q[2]) begin
          state_d = ST_E0;
        end else begin
          state_d = ST_MID;
        end
      end
      ST_MID:   state_d = (sy_q[0] == sy_q[1]) ? ST_E0 : ST_MID_W;
      ST_MID_W: state_d = div_stat.done ? ST_E0 : ST_MID_W;
      ST_E0:    state_d = (num0 == '0) ? ST_E1 : ST_E0_W;
      ST_E0_W:  state_d = div_stat.done ? ST_E1 : ST_E0_W;
      ST_E1:    state_d = (num1 == '0) ? ST_IDLE : ST_E1_W;
      ST_E1_W:  state_d = div_stat.done ? ST_IDLE : ST_E1_W;
      ST_SPAN: begin
        if (row_q == sy_q[1] && phase_q == tssr_pkg::PH_TOP && sy_q[0] < sy_q[1]) begin
          state_d = ST_E0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= tssr_pkg::CFG_WIDTH_RESET;
      phase_q     <= tssr_pkg::PH_IDLE;
      out_valid_q <= 1'b0;
      bottom_q    <= 1'b0;
      row_q       <= '0;
      label_q     <= '0;
      split_q     <= '0;
      for (int i = 0; i < 3; i++) begin
        sx_q[i] <= '0;
        sy_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        pos_q[i]  <= '0;
        step_q[i] <= '0;
        vert_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser_i == tssr_pkg::OP_LOAD) begin
            for (int i = 0; i < 3; i++) begin
              sx_q[i] <= srt[i][C-1:0];
              sy_q[i] <= srt[i][2*C-1:C];
            end
            label_q <= s_axis_tdata_i[6*C+LABEL_BITS-1:6*C];
          end else if (in_acc && phase_q != tssr_pkg::PH_IDLE) begin
            // advance each edge before its row is filled
            for (int i = 0; i < 2; i++) begin
              if (!vert_q[i]) begin
                pos_q[i] <= (phase_q == tssr_pkg::PH_TOP) ? pos_q[i] - step_q[i]
                                                          : pos_q[i] + step_q[i];
              end
            end
          end
        end
        ST_SETUP: begin
          if (sy_q[0] == sy_q[2]) begin
            pos_q[0]  <= xq0;
            pos_q[1]  <= xq2;
            step_q[0] <= '0;
            step_q[1] <= '0;
            vert_q[0] <= 1'b1;
            vert_q[1] <= 1'b1;
            row_q     <= sy_q[0];
            phase_q   <= tssr_pkg::PH_BOTTOM;
          end else if (sy_q[1] == sy_q[2]) begin
            split_q  <= xq2;
            pos_q[0] <= xq0;
            pos_q[1] <= xq0;
            row_q    <= sy_q[0];
            phase_q  <= tssr_pkg::PH_BOTTOM;
            bottom_q <= 1'b1;
          end else begin
            pos_q[0] <= xq2;
            pos_q[1] <= xq2;
            row_q    <= sy_q[2];
            phase_q  <= tssr_pkg::PH_TOP;
            bottom_q <= 1'b0;
          end
        end
        ST_MID: begin
          if (sy_q[0] == sy_q[1]) begin
            split_q <= xq1;
          end
        end
        ST_MID_W: begin
          if (div_stat.done) begin
            split_q <= xq0 + quo;
          end
        end
        ST_E0: begin
          vert_q[0] <= (num0 == '0);
          step_q[0] <= '0;
        end
        ST_E0_W: begin
          if (div_stat.done) begin
            step_q[0] <= quo;
          end
        end
        ST_E1: begin
          vert_q[1] <= (num1 == '0);
          step_q[1] <= '0;
        end
        ST_E1_W: begin
          if (div_stat.done) begin
            step_q[1] <= quo;
          end
        end
        ST_SPAN: begin
          out_valid_q <= 1'b1;
          if (row_q == sy_q[1]) begin
            if (phase_q == tssr_pkg::PH_TOP && sy_q[0] < sy_q[1]) begin
              pos_q[0] <= xq0;
              pos_q[1] <= xq0;
              row_q    <= sy_q[0];
              phase_q  <= tssr_pkg::PH_BOTTOM;
              bottom_q <= 1'b1;
            end else begin
              phase_q <= tssr_pkg::PH_IDLE;
            end
          end else if (phase_q == tssr_pkg::PH_TOP) begin
            row_q <= row_q - C'(1);
          end else begin
            row_q <= row_q + C'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SPAN) begin
      out_row_q   <= row_q;
      out_start_q <= (s_i > $signed(QI_W'({C{1'b1}}))) ? {C{1'b1}} : s_i[C-1:0];
      out_end_q   <= (e_i < 0) ? '0 : e_i[C-1:0];
      out_label_q <= label_q;
      out_empty_q <= (s_i > e_i);
      out_last_q  <= (row_q == sy_q[1]) &&
                     !(phase_q == tssr_pkg::PH_TOP && sy_q[0] < sy_q[1]);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_label_q, out_end_q, out_start_q, out_row_q});
  assign m_axis_tuser_o  = out_empty_q;
  assign m_axis_tlast_o  = out_last_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_MID_W || state_q == ST_E0_W || state_q == ST_E1_W))
    else $error("divider result with no wait state");

  a_valid_from_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SPAN))
    else $error("span word raised outside span state");

  a_span_needs_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPAN) |-> (phase_q != tssr_pkg::PH_IDLE && !out_valid_q))
    else $error("span state with no active triangle or full output");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for triangle_scanline_span_rasterizer_top.
// Drives load and step words with random gaps and output stalls, and predicts spans
// with its own model of the edge walk. Depends on tssr_pkg and the RTL top only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 12;
  localparam int FB = 16;
  localparam int LB = 20;
  localparam int CW = tssr_pkg::CFG_W;
  localparam int SDW = ((6*CB+LB+7)/8)*8;
  localparam int MDW = ((3*CB+LB+7)/8)*8;
  localparam longint ONE = 64'sd1 << FB;
  localparam int CMAX = (1 << CB) - 1;
  localparam int SETTLE = 320;

  typedef struct packed {
    logic [LB-1:0] label;
    logic [CB-1:0] col_end;
    logic [CB-1:0] col_start;
    logic [CB-1:0] row;
    logic          empty;
    logic          last;
  } span_t;

  typedef struct {
    logic       op;
    int         x[3];
    int         y[3];
    int         idx;
    bit         typed;
    bit         has_span;
    span_t      span;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [SDW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = tssr_pkg::OP_STEP;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [MDW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;

  triangle_scanline_span_rasterizer_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int        vx[3], vy[3];
  longint    mid_x, epos[2], estep[2];
  bit        evert[2];
  int        cur_row;
  logic [1:0] phase = tssr_pkg::PH_IDLE;
  int        label_q;
  int        width_q = 640;

  span_t     spans_due[$];
  int        errors = 0, mismatches = 0, spans_seen = 0, words_sent = 0;
  bit        no_idle = 1'b0, hold_off = 1'b0, cur_typed = 1'b0, cur_has = 1'b0;
  span_t     cur_span;

  function automatic void set_edge(int e, longint from, longint to, longint dy, longint st);
    epos[e] = st;
    evert[e] = (from == to);
    estep[e] = (evert[e] || dy == 0) ? 64'sd0 : (to - from) / dy;
  endfunction

  function automatic void begin_lower_part();
    set_edge(0, vx[0] * ONE, vx[1] * ONE, vy[1] - vy[0], vx[0] * ONE);
    set_edge(1, vx[0] * ONE, mid_x, vy[1] - vy[0], vx[0] * ONE);
    cur_row = vy[0];
    phase = tssr_pkg::PH_BOTTOM;
  endfunction

  // sorted order kept as vx/vy[0..2]
  function automatic void load_triangle(int x[3], int y[3], int idx);
    int tx, ty;
    longint bx, dy, num;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2 - i; j++)
        if (y[j] > y[j+1] || (y[j] == y[j+1] && x[j] > x[j+1])) begin
          tx = x[j]; x[j] = x[j+1]; x[j+1] = tx;
          ty = y[j]; y[j] = y[j+1]; y[j+1] = ty;
        end
    vx = x;
    vy = y;
    label_q = idx;
    mid_x = 0;
    if (y[0] == y[2]) begin
      epos[0] = x[0] * ONE;
      epos[1] = x[2] * ONE;
      estep = '{0, 0};
      evert = '{1'b1, 1'b1};
      cur_row = y[0];
      phase = tssr_pkg::PH_BOTTOM;
    end else if (y[1] == y[2]) begin
      mid_x = x[2] * ONE;
      begin_lower_part();
    end else begin
      bx = x[2] * ONE;
      dy = y[2] - y[1];
      if (y[0] == y[1]) mid_x = x[1] * ONE;
      else begin
        num = longint'(y[1] - y[0]) * longint'(x[2] - x[0]) * ONE;
        mid_x = x[0] * ONE + num / longint'(y[2] - y[0]);
      end
      set_edge(0, (y[0] == y[1] ? x[0] : x[1]) * ONE, bx, dy, bx);
      set_edge(1, mid_x, bx, dy, bx);
      cur_row = y[2];
      phase = tssr_pkg::PH_TOP;
    end
  endfunction

  function automatic bit next_span(output span_t r);
    longint w, lo, hi, s, e;
    r = '0;
    if (phase == tssr_pkg::PH_IDLE) return 1'b0;
    for (int i = 0; i < 2; i++)
      if (!evert[i]) epos[i] = (phase == tssr_pkg::PH_TOP) ? epos[i] - estep[i]
                                                           : epos[i] + estep[i];
    w = width_q < 1 ? 1 : (width_q > CMAX + 1 ? CMAX + 1 : width_q);
    lo = epos[0] < epos[1] ? epos[0] : epos[1];
    hi = epos[0] < epos[1] ? epos[1] : epos[0];
    if (lo < 0) lo = 0;
    if (hi > (w - 1) * ONE) hi = (w - 1) * ONE;
    s = lo / ONE;
    e = hi / ONE;
    r.row = CB'(cur_row);
    r.col_start = CB'(s > CMAX ? CMAX : s);
    r.col_end = CB'(e < 0 ? 0 : e);
    r.label = LB'(label_q);
    r.empty = s > e;
    if (cur_row == vy[1]) begin
      if (phase == tssr_pkg::PH_TOP && vy[0] < vy[1]) begin_lower_part();
      else begin
        phase = tssr_pkg::PH_IDLE;
        r.last = 1'b1;
      end
    end else if (phase == tssr_pkg::PH_TOP) cur_row = (cur_row - 1) & CMAX;
    else cur_row = (cur_row + 1) & CMAX;
    return 1'b1;
  endfunction

  // input monitor: ready and valid are stable at the falling edge
  always @(negedge clk_i) begin
    int x[3], y[3];
    span_t r;
    bit got;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      words_sent++;
      if (s_axis_tuser_i == tssr_pkg::OP_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          x[i] = int'(s_axis_tdata_i[24*i +: CB]);
          y[i] = int'(s_axis_tdata_i[24*i+12 +: CB]);
        end
        load_triangle(x, y, int'(s_axis_tdata_i[72 +: LB]));
      end else begin
        got = next_span(r);
        if (cur_typed) begin
          got = cur_has;
          r = cur_span;
        end
        if (got) spans_due.push_back(r);
      end
    end
  end

  // output monitor
  always @(negedge clk_i) begin
    span_t act, exp_s;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      spans_seen++;
      act.row = m_axis_tdata_o[0 +: CB];
      act.col_start = m_axis_tdata_o[12 +: CB];
      act.col_end = m_axis_tdata_o[24 +: CB];
      act.label = m_axis_tdata_o[36 +: LB];
      act.empty = m_axis_tuser_o;
      act.last = m_axis_tlast_o;
      if (spans_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected span %p", act);
      end else begin
        exp_s = spans_due.pop_front();
        if (act !== exp_s) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("span mismatch: exp row %0d start %0d end %0d label %h empty %b last %b",
                     exp_s.row, exp_s.col_start, exp_s.col_end, exp_s.label,
                     exp_s.empty, exp_s.last,
                     " / got row %0d start %0d end %0d label %h empty %b last %b",
                     act.row, act.col_start, act.col_end, act.label, act.empty, act.last);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (no_idle) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(99) >= 13);
  end

  initial begin
    wait (words_sent >= 400);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    @(negedge clk_i);
    hold_off = 1'b0;
  end

  task automatic send_word(row_t r);
    logic [SDW-1:0] d;
    d = '0;
    if (!no_idle && $urandom_range(99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    for (int i = 0; i < 3; i++) begin
      d[24*i +: CB] = CB'(r.x[i]);
      d[24*i+12 +: CB] = CB'(r.y[i]);
    end
    d[72 +: LB] = LB'(r.idx);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= r.op;
    s_axis_tdata_i <= d;
    cur_typed <= r.typed;
    cur_has <= r.has_span;
    cur_span <= r.span;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    cur_typed <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_width(int w);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CW'(w);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_q = w;
  endtask

  function automatic row_t tri_row(int xa, int ya, int xb, int yb, int xc, int yc, int idx);
    row_t r;
    r = '{op: tssr_pkg::OP_LOAD, x: '{xa, xb, xc}, y: '{ya, yb, yc}, idx: idx,
          typed: 1'b0, has_span: 1'b0, span: '0};
    return r;
  endfunction

  function automatic row_t step_row(bit typed = 0, bit has = 0, span_t s = '0);
    row_t r;
    r = '{op: tssr_pkg::OP_STEP, x: '{0, 0, 0}, y: '{0, 0, 0}, idx: 0,
          typed: typed, has_span: has, span: s};
    return r;
  endfunction

  task automatic random_triangle();
    int base, x[3], y[3], n;
    bit noise;
    noise = ($urandom_range(99) < 10);
    base = $urandom_range(CMAX - 40);
    for (int i = 0; i < 3; i++) begin
      x[i] = $urandom_range(CMAX);
      y[i] = noise ? $urandom_range(CMAX) : base + $urandom_range($urandom_range(1) ? 3 : 16);
    end
    if ($urandom_range(9) == 0) y[1] = y[0];
    if ($urandom_range(9) == 0) x[2] = x[0];
    if ($urandom_range(3) == 0) for (int i = 0; i < 3; i++) x[i] = $urandom_range(64);
    send_word(tri_row(x[0], y[0], x[1], y[1], x[2], y[2], $urandom_range(20'hFFFFF)));
    n = noise ? $urandom_range(6) : 5 + $urandom_range(40);
    if ($urandom_range(7) == 0) n = $urandom_range(3);
    for (int i = 0; i < n; i++) send_word(step_row());
  endtask

  row_t plan[$];
  int   widths[7] = '{640, 1, 4096, 8191, 0, 37, 2000};

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset no triangle is active
    plan.push_back(step_row(1, 0));
    plan.push_back(tri_row(3, 5, 10, 5, 7, 5, 20'hFFFFF));
    plan.push_back(step_row(1, 1, '{label: 20'hFFFFF, col_end: 10, col_start: 3, row: 5,
                                    empty: 0, last: 1}));
    plan.push_back(step_row(1, 0));
    // wide triangle clamped at the right border, label zero
    plan.push_back(tri_row(4095, 100, 0, 102, 4095, 104, 0));
    repeat (6) plan.push_back(step_row());
    // flat bottom, vertical edge
    plan.push_back(tri_row(0, 4090, 0, 4095, 9, 4095, 20'h5A5A5));
    repeat (3) plan.push_back(step_row());
    // reload while a triangle is still being walked
    plan.push_back(tri_row(20, 7, 2, 9, 1, 7, 20'h00001));
    repeat (4) plan.push_back(step_row());
    foreach (plan[i]) send_word(plan[i]);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) write_width(widths[p]);
      no_idle = (p == 2);
      for (int k = 0; k < 10; k++) random_triangle();
      while (words_sent < 220 * (p + 1)) random_triangle();
    end
    no_idle = 1'b0;
    quiesce();
    $display("Sent %0d words over %0d width settings, checked %0d spans.",
             words_sent, 7, spans_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d spans outstanding", spans_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/tssr_pkg.sv
rtl/tssr_divider.sv
rtl/triangle_scanline_span_rasterizer_top.sv
dv/tb_top.sv
